// ----- rtl/core/i2cew_pkg.sv -----
// i2cew_pkg: shared constants, codes and the transfer state type for the
// eeprom word transfer master; no dependencies
`timescale 1ns / 1ps

package i2cew_pkg;

    // bytes in one eeprom word
    localparam int WORD_BYTES = 4;

    localparam int BCNT_W  = $clog2(WORD_BYTES + 1);
    localparam int BUF_W   = (WORD_BYTES * 8 > 32) ? WORD_BYTES * 8 : 32;
    localparam int WAIT_W  = 20;
    localparam int DEV_W   = 7;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT     = 1'b1;

    localparam logic [DEV_W-1:0]  DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [WAIT_W-1:0] WRITE_WAIT_RST     = 20'd20000;

    // actions carried by a word
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // operation state
    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WAIT  = 2'd3;

    // bus segments
    localparam logic [2:0] SEG_START  = 3'd0;
    localparam logic [2:0] SEG_DEVW   = 3'd1;
    localparam logic [2:0] SEG_ADDR   = 3'd2;
    localparam logic [2:0] SEG_WDATA  = 3'd3;
    localparam logic [2:0] SEG_STOP   = 3'd4;
    localparam logic [2:0] SEG_RSTART = 3'd5;
    localparam logic [2:0] SEG_DEVR   = 3'd6;
    localparam logic [2:0] SEG_RDATA  = 3'd7;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        seg;
        logic [5:0]        step;
        logic [BCNT_W-1:0] byte_cnt;
        logic [7:0]        shift;
        logic [BUF_W-1:0]  buffer;
        logic [7:0]        addr;
        logic              nack;
        logic [WAIT_W-1:0] wait_cnt;
        logic              scl;
        logic              sda;
        logic [31:0]       read_result;
    } xfer_state_t;

    // phase within a three-step bit slot of a sent byte
    function automatic logic [1:0] bit_phase(input logic [4:0] s);
        logic [1:0] ph;
        if (s inside {5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21})
            ph = 2'd0;
        else if (s inside {5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22})
            ph = 2'd1;
        else
            ph = 2'd2;
        return ph;
    endfunction

endpackage

// ----- rtl/core/i2cew_engine.sv -----
// i2cew_engine: one pin step of the bus sequence, from current state to next
// depends on i2cew_pkg
`timescale 1ns / 1ps

module i2cew_engine (
    input  i2cew_pkg::xfer_state_t       st,
    input  logic [1:0]                   action,
    input  logic [7:0]                   mem_addr,
    input  logic [31:0]                  write_word,
    input  logic                         sda_in,
    input  logic [i2cew_pkg::DEV_W-1:0]  dev_addr,
    input  logic [i2cew_pkg::WAIT_W-1:0] wait_ticks,
    output i2cew_pkg::xfer_state_t       st_next,
    output logic                         done
);
    import i2cew_pkg::*;

    xfer_state_t n;
    logic        last;
    logic [5:0]  s;

    always_comb begin
        n    = st;
        done = 1'b0;
        last = 1'b0;

        if (st.op == OP_IDLE && (action == ACT_WRITE || action == ACT_READ)) begin
            n.op       = (action == ACT_WRITE) ? OP_WRITE : OP_READ;
            n.addr     = mem_addr;
            n.buffer   = (action == ACT_WRITE) ? BUF_W'(write_word) : '0;
            n.nack     = 1'b0;
            n.byte_cnt = '0;
            n.seg      = SEG_START;
            n.step     = '0;
            n.shift    = '0;
        end

        s = n.step;

        if (n.op == OP_WRITE || n.op == OP_READ) begin
            case (n.seg)
                SEG_START, SEG_RSTART: begin
                    case (s)
                        6'd0:    n.sda = 1'b1;
                        6'd1:    n.scl = 1'b1;
                        6'd2:    n.sda = 1'b0;
                        default: begin
                            n.scl = 1'b0;
                            last  = 1'b1;
                        end
                    endcase
                end
                SEG_STOP: begin
                    case (s)
                        6'd0:    n.sda = 1'b0;
                        6'd1:    n.scl = 1'b1;
                        default: begin
                            n.sda = 1'b1;
                            last  = 1'b1;
                        end
                    endcase
                end
                SEG_RDATA: begin
                    if (s == 6'd0) begin
                        n.sda = 1'b1;
                    end else if (s <= 6'd16) begin
                        if (s[0]) begin
                            n.scl   = 1'b1;
                            n.shift = {n.shift[6:0], sda_in};
                        end else begin
                            n.scl = 1'b0;
                        end
                    end else if (s == 6'd17) begin
                        // nack the final byte, ack the rest
                        n.sda = (n.byte_cnt >= BCNT_W'(WORD_BYTES - 1));
                    end else if (s == 6'd18) begin
                        n.scl = 1'b1;
                    end else if (s == 6'd19) begin
                        n.scl = 1'b0;
                    end else begin
                        n.sda = 1'b1;
                        last  = 1'b1;
                    end
                end
                default: begin
                    // byte sent by the master
                    if (s < 6'd24) begin
                        case (bit_phase(s[4:0]))
                            2'd0:    n.sda = n.shift[7];
                            2'd1:    n.scl = 1'b1;
                            default: begin
                                n.scl   = 1'b0;
                                n.shift = {n.shift[6:0], 1'b0};
                            end
                        endcase
                    end else if (s == 6'd24) begin
                        n.sda = 1'b1;
                    end else if (s == 6'd25) begin
                        n.scl = 1'b1;
                        if (sda_in)
                            n.nack = 1'b1;
                    end else begin
                        n.scl = 1'b0;
                        last  = 1'b1;
                    end
                end
            endcase

            n.step = n.step + 6'd1;

            if (last) begin
                n.step = '0;
                case (n.seg)
                    SEG_START: begin
                        n.seg   = SEG_DEVW;
                        n.shift = {dev_addr, 1'b0};
                    end
                    SEG_DEVW: begin
                        n.seg   = SEG_ADDR;
                        n.shift = n.addr;
                    end
                    SEG_ADDR: begin
                        n.byte_cnt = '0;
                        if (n.op == OP_WRITE) begin
                            n.seg   = SEG_WDATA;
                            n.shift = n.buffer[7:0];
                        end else begin
                            n.seg   = SEG_RSTART;
                            n.shift = '0;
                        end
                    end
                    SEG_WDATA: begin
                        n.byte_cnt = n.byte_cnt + BCNT_W'(1);
                        if (n.byte_cnt < BCNT_W'(WORD_BYTES)) begin
                            n.seg   = SEG_WDATA;
                            n.shift = 8'(n.buffer >> {n.byte_cnt, 3'b000});
                        end else begin
                            n.seg   = SEG_STOP;
                            n.shift = '0;
                        end
                    end
                    SEG_RSTART: begin
                        n.seg   = SEG_DEVR;
                        n.shift = {dev_addr, 1'b1};
                    end
                    SEG_DEVR: begin
                        n.byte_cnt = '0;
                        n.buffer   = '0;
                        n.seg      = SEG_RDATA;
                        n.shift    = '0;
                    end
                    SEG_RDATA: begin
                        n.buffer   = n.buffer | (BUF_W'(n.shift) << {n.byte_cnt, 3'b000});
                        n.byte_cnt = n.byte_cnt + BCNT_W'(1);
                        n.seg      = (n.byte_cnt < BCNT_W'(WORD_BYTES)) ? SEG_RDATA : SEG_STOP;
                        n.shift    = '0;
                    end
                    default: begin
                        if (n.op == OP_READ) begin
                            n.read_result = n.buffer[31:0];
                            n.op          = OP_IDLE;
                            done          = 1'b1;
                        end else if (wait_ticks == '0) begin
                            n.op = OP_IDLE;
                            done = 1'b1;
                        end else begin
                            n.wait_cnt = wait_ticks;
                            n.op       = OP_WAIT;
                        end
                    end
                endcase
            end
        end else if (n.op == OP_WAIT) begin
            n.wait_cnt = n.wait_cnt - WAIT_W'(1);
            if (n.wait_cnt == '0) begin
                n.op = OP_IDLE;
                done = 1'b1;
            end
        end

        st_next = n;
    end

endmodule

// ----- rtl/core/i2c_eeprom_word_transfer.sv -----
// i2c_eeprom_word_transfer: i2c master moving one word to or from an eeprom
// an accepted tick word's result word is registered and offered next cycle
// throughput: one tick word per cycle while m_ready is high, set by the
// single-pass step logic between the state register and the result register
// reset (aresetn low, synchronous): bus idle with both lines released,
// last read word zero, registers at their defaults; depends on i2cew_pkg
`timescale 1ns / 1ps

module i2c_eeprom_word_transfer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [i2cew_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cew_pkg::WAIT_W-1:0]    cfg_wdata,
    // tick words in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [7:0]                      s_mem_addr,
    input  logic [31:0]                     s_write_word,
    input  logic                            s_sda_in,
    // result words out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_scl,
    output logic                            m_sda_out,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic [31:0]                     m_read_word,
    output logic                            m_nack_seen
);
    import i2cew_pkg::*;

    // configuration registers
    logic [DEV_W-1:0]  dev_addr_reg;
    logic [WAIT_W-1:0] wait_ticks_reg;

    // transfer state, advanced once per accepted word
    xfer_state_t st_reg;
    xfer_state_t st_next;
    logic        step_done;

    // output register
    logic        m_valid_reg;
    logic        scl_reg;
    logic        sda_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] read_word_reg;
    logic        nack_reg;

    logic s_accept;

    // accept while the output slot is empty or being drained this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= DEVICE_ADDRESS_RST;
            wait_ticks_reg <= WRITE_WAIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg   <= cfg_wdata[DEV_W-1:0];
                REG_WRITE_WAIT:     wait_ticks_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // one pin step of the bus sequence
    i2cew_engine u_engine (
        .st         (st_reg),
        .action     (s_action),
        .mem_addr   (s_mem_addr),
        .write_word (s_write_word),
        .sda_in     (s_sda_in),
        .dev_addr   (dev_addr_reg),
        .wait_ticks (wait_ticks_reg),
        .st_next    (st_next),
        .done       (step_done)
    );

    // state register: bus released, everything else cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{op: OP_IDLE, seg: SEG_START, scl: 1'b1, sda: 1'b1, default: '0};
        end else if (s_accept) begin
            st_reg <= st_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the state after this word's step
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            scl_reg       <= st_next.scl;
            sda_reg       <= st_next.sda;
            busy_reg      <= (st_next.op != OP_IDLE);
            done_reg      <= step_done;
            read_word_reg <= st_next.read_result;
            nack_reg      <= st_next.nack;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl       = scl_reg;
    assign m_sda_out   = sda_reg;
    assign m_busy_res  = busy_reg;
    assign m_done_res  = done_reg;
    assign m_read_word = read_word_reg;
    assign m_nack_seen = nack_reg;

    // a finished transfer never reports busy on the same word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> !busy_reg)
        else $error("done reported together with busy");

    // both lines stay released during the post-write wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.op == OP_WAIT |-> st_reg.scl && st_reg.sda)
        else $error("bus not released during write wait");

    // a plain tick while idle leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && st_reg.op == OP_IDLE && s_action == ACT_TICK
        |=> st_reg.op == OP_IDLE)
        else $error("idle tick started a transfer");

endmodule

// ----- tb/tb_i2c_eeprom_word_transfer.sv -----
// tb_i2c_eeprom_word_transfer: self-checking bench for the eeprom word transfer master
// directed table transfers, then random tick words in several idling phases, each result
// word checked against a local bus predictor or a typed result; depends on i2cew_pkg
`timescale 1ns / 1ps

module tb_i2c_eeprom_word_transfer;

    import i2cew_pkg::*;

    // action code that the block treats as a plain tick
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS = 40;
    localparam int TAIL_TICKS = 100;
    // generous ceiling on the whole run, in ns
    localparam int RUN_LIMIT_NS = 3_000_000;

    typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

    // one result word as seen on the m_ side
    typedef struct packed {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [31:0] rd;
        logic        nack;
    } bus_res_t;

    // one directed transfer: optional wait setting, the starting word, then ticks to idle
    typedef struct packed {
        logic [1:0]        act;
        logic [7:0]        addr;
        logic [31:0]       word;
        sda_mode_t         mode;
        logic              stray;
        logic              set_wait;
        logic [WAIT_W-1:0] wait_val;
        logic              typed;
        bus_res_t          res;
    } dir_row_t;

    // results that can be read straight off the bus sequence
    localparam bus_res_t RES_IDLE       = '{1'b1, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0};
    localparam bus_res_t RES_READ_ONES  = '{1'b1, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1};
    localparam bus_res_t RES_DONE_CLEAN = '{1'b1, 1'b1, 1'b0, 1'b1, 32'h0, 1'b0};
    localparam bus_res_t RES_DONE_NACK  = '{1'b1, 1'b1, 1'b0, 1'b1, 32'h0, 1'b1};

    localparam int DIR_ROWS_N = 9;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // plain tick straight after reset: lines released, nothing running
        '{ACT_TICK,   8'h00, 32'h0000_0000, SDA_LOW,  1'b0, 1'b0, 20'd0, 1'b1, RES_IDLE},
        // unused action code behaves as a tick
        '{ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, SDA_HIGH, 1'b0, 1'b0, 20'd0, 1'b1, RES_IDLE},
        // read with the line floating high: all ones, every ack missed
        '{ACT_READ,   8'h00, 32'h0000_0000, SDA_HIGH, 1'b0, 1'b0, 20'd0, 1'b1, RES_READ_ONES},
        // read with the line held low: all zeros, every ack seen
        '{ACT_READ,   8'hFF, 32'hFFFF_FFFF, SDA_LOW,  1'b0, 1'b0, 20'd0, 1'b1, RES_DONE_CLEAN},
        // write with a short wait, last read word must survive
        '{ACT_WRITE,  8'hFF, 32'hFFFF_FFFF, SDA_LOW,  1'b0, 1'b1, 20'd2, 1'b1, RES_DONE_CLEAN},
        // zero wait: done on the final stop step, acks all missed
        '{ACT_WRITE,  8'h00, 32'h0000_0000, SDA_HIGH, 1'b0, 1'b1, 20'd0, 1'b1, RES_DONE_NACK},
        // one-tick wait with actions arriving while busy
        '{ACT_WRITE,  8'h5A, 32'hA5C3_0F96, SDA_RAND, 1'b1, 1'b1, 20'd1, 1'b0, RES_IDLE},
        '{ACT_READ,   8'hC3, 32'h0000_0000, SDA_RAND, 1'b1, 1'b0, 20'd0, 1'b0, RES_IDLE},
        '{ACT_WRITE,  8'h3C, 32'h1234_5678, SDA_LOW,  1'b1, 1'b1, 20'd3, 1'b0, RES_IDLE}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WAIT_W-1:0]     cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_action;
    logic [7:0]            s_mem_addr;
    logic [31:0]           s_write_word;
    logic                  s_sda_in;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_scl;
    logic                  m_sda_out;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic [31:0]           m_read_word;
    logic                  m_nack_seen;

    // idling percentages of the current phase
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int mismatches = 0;

    // result words still owed by the block, oldest first
    bus_res_t pending_results[$];

    // predictor copy of the registers and the transfer state
    logic [DEV_W-1:0]  cfg_dev;
    logic [WAIT_W-1:0] cfg_wait;
    logic [1:0]        xf_op;
    logic [2:0]        xf_seg;
    int                xf_step;
    int                xf_bytes;
    logic [7:0]        xf_shift;
    logic [BUF_W-1:0]  xf_buf;
    logic [7:0]        xf_addr;
    logic              xf_nack;
    logic [WAIT_W-1:0] xf_wait;
    logic              line_scl;
    logic              line_sda;
    logic [31:0]       last_read;

    i2c_eeprom_word_transfer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_mem_addr   (s_mem_addr),
        .s_write_word (s_write_word),
        .s_sda_in     (s_sda_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl        (m_scl),
        .m_sda_out    (m_sda_out),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_read_word  (m_read_word),
        .m_nack_seen  (m_nack_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("i2c_eeprom_word_transfer regression: fail");
        $finish;
    end

    // start a new bus segment with the byte it is to send
    function automatic void open_segment(input logic [2:0] seg, input logic [7:0] byte_v);
        xf_seg = seg;
        xf_step = 0;
        xf_shift = byte_v;
    endfunction

    // one tick of the bus sequencer: start handling, one pin step or wait count,
    // then the segment change; returns the result word the tick should give
    function automatic bus_res_t advance_bus(input logic [1:0] act, input logic [7:0] addr,
                                             input logic [31:0] word, input logic sda);
        bus_res_t r;
        logic     fin;
        logic     last;
        fin = 1'b0;
        last = 1'b0;
        // a start is only taken while nothing runs, and steps on the same tick
        if (xf_op == OP_IDLE && (act == ACT_WRITE || act == ACT_READ)) begin
            xf_op = (act == ACT_WRITE) ? OP_WRITE : OP_READ;
            xf_addr = addr;
            xf_buf = '0;
            if (act == ACT_WRITE)
                xf_buf[31:0] = word;
            xf_nack = 1'b0;
            xf_bytes = 0;
            open_segment(SEG_START, 8'h00);
        end
        if (xf_op == OP_WRITE || xf_op == OP_READ) begin
            if (xf_seg == SEG_START || xf_seg == SEG_RSTART) begin
                case (xf_step)
                    0: line_sda = 1'b1;
                    1: line_scl = 1'b1;
                    2: line_sda = 1'b0;
                    default: begin
                        line_scl = 1'b0;
                        last = 1'b1;
                    end
                endcase
            end else if (xf_seg == SEG_STOP) begin
                case (xf_step)
                    0: line_sda = 1'b0;
                    1: line_scl = 1'b1;
                    default: begin
                        line_sda = 1'b1;
                        last = 1'b1;
                    end
                endcase
            end else if (xf_seg == SEG_RDATA) begin
                // release, eight clocked samples, ack or nack, release again
                if (xf_step == 0) begin
                    line_sda = 1'b1;
                end else if (xf_step <= 16) begin
                    if (xf_step % 2 == 1) begin
                        line_scl = 1'b1;
                        xf_shift = {xf_shift[6:0], sda};
                    end else begin
                        line_scl = 1'b0;
                    end
                end else if (xf_step == 17) begin
                    line_sda = (xf_bytes + 1 >= WORD_BYTES);
                end else if (xf_step == 18) begin
                    line_scl = 1'b1;
                end else if (xf_step == 19) begin
                    line_scl = 1'b0;
                end else begin
                    line_sda = 1'b1;
                    last = 1'b1;
                end
            end else begin
                // byte driven by the master, msb first, then the ack slot
                if (xf_step < 24) begin
                    case (xf_step % 3)
                        0: line_sda = xf_shift[7];
                        1: line_scl = 1'b1;
                        default: begin
                            line_scl = 1'b0;
                            xf_shift = {xf_shift[6:0], 1'b0};
                        end
                    endcase
                end else if (xf_step == 24) begin
                    line_sda = 1'b1;
                end else if (xf_step == 25) begin
                    line_scl = 1'b1;
                    if (sda)
                        xf_nack = 1'b1;
                end else begin
                    line_scl = 1'b0;
                    last = 1'b1;
                end
            end
            xf_step = (xf_step + 1) & 63;
            if (last) begin
                case (xf_seg)
                    SEG_START: open_segment(SEG_DEVW, {cfg_dev, 1'b0});
                    SEG_DEVW:  open_segment(SEG_ADDR, xf_addr);
                    SEG_ADDR: begin
                        xf_bytes = 0;
                        if (xf_op == OP_WRITE)
                            open_segment(SEG_WDATA, xf_buf[7:0]);
                        else
                            open_segment(SEG_RSTART, 8'h00);
                    end
                    SEG_WDATA: begin
                        xf_bytes++;
                        if (xf_bytes < WORD_BYTES)
                            open_segment(SEG_WDATA, xf_buf[8*xf_bytes +: 8]);
                        else
                            open_segment(SEG_STOP, 8'h00);
                    end
                    SEG_RSTART: open_segment(SEG_DEVR, {cfg_dev, 1'b1});
                    SEG_DEVR: begin
                        xf_bytes = 0;
                        xf_buf = '0;
                        open_segment(SEG_RDATA, 8'h00);
                    end
                    SEG_RDATA: begin
                        // low byte first
                        xf_buf[8*xf_bytes +: 8] = xf_shift;
                        xf_bytes++;
                        if (xf_bytes < WORD_BYTES)
                            open_segment(SEG_RDATA, 8'h00);
                        else
                            open_segment(SEG_STOP, 8'h00);
                    end
                    default: begin
                        // stop finished: reads end here, writes may go on to wait
                        if (xf_op == OP_READ) begin
                            last_read = xf_buf[31:0];
                            xf_op = OP_IDLE;
                            fin = 1'b1;
                        end else if (cfg_wait == '0) begin
                            xf_op = OP_IDLE;
                            fin = 1'b1;
                        end else begin
                            xf_wait = cfg_wait;
                            xf_op = OP_WAIT;
                        end
                    end
                endcase
            end
        end else if (xf_op == OP_WAIT) begin
            xf_wait = xf_wait - 1'b1;
            if (xf_wait == '0) begin
                xf_op = OP_IDLE;
                fin = 1'b1;
            end
        end
        r.scl = line_scl;
        r.sda = line_sda;
        r.busy = (xf_op != OP_IDLE);
        r.done = fin;
        r.rd = last_read;
        r.nack = xf_nack;
        return r;
    endfunction

    // offer one tick word, wait for it to be taken, return what it should produce
    task automatic send_word(input logic [1:0] act, input logic [7:0] addr,
                             input logic [31:0] word, input sda_mode_t mode,
                             output bus_res_t res);
        logic sda;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        case (mode)
            SDA_LOW:  sda = 1'b0;
            SDA_HIGH: sda = 1'b1;
            default: begin
                // acks mostly given, the odd one missed; everything else random
                if (xf_op != OP_IDLE && xf_op != OP_WAIT && xf_step == 25)
                    sda = ($urandom_range(11) == 0);
                else
                    sda = 1'($urandom);
            end
        endcase
        s_valid <= 1'b1;
        s_action <= act;
        s_mem_addr <= addr;
        s_write_word <= word;
        s_sda_in <= sda;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        res = advance_bus(act, addr, word, sda);
    endtask

    // let every owed result come back, then a few quiet cycles
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_DEVICE_ADDRESS)
            cfg_dev = val[DEV_W-1:0];
        else
            cfg_wait = val;
    endtask

    // one random phase: new settings, random words, then ticks until the bus is idle
    task automatic run_phase(input int src_pct, input int sink_pct, input logic [DEV_W-1:0] dev,
                             input logic [WAIT_W-1:0] wait_v, input int count);
        bus_res_t   pred;
        logic [1:0] act;
        int         k;
        int         pick;
        settle();
        write_reg(REG_DEVICE_ADDRESS, {{(WAIT_W-DEV_W){1'b0}}, dev});
        write_reg(REG_WRITE_WAIT, wait_v);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (k = 0; k < count; k++) begin
            if (xf_op == OP_IDLE) begin
                // mostly real transfers, some noise between them
                pick = $urandom_range(19);
                if (pick < 7)
                    act = ACT_WRITE;
                else if (pick < 14)
                    act = ACT_READ;
                else if (pick < 17)
                    act = ACT_UNUSED;
                else
                    act = ACT_TICK;
            end else begin
                // stray actions while busy must be ignored
                act = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : ACT_TICK;
            end
            send_word(act, 8'($urandom), $urandom, SDA_RAND, pred);
            pending_results.push_back(pred);
        end
        while (xf_op != OP_IDLE) begin
            send_word(ACT_TICK, 8'($urandom), $urandom, SDA_RAND, pred);
            pending_results.push_back(pred);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got);
        if (got !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got);
            mismatches++;
        end
    endtask

    // receiver stalls at random according to the phase
    always @(posedge aclk) begin
        m_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    // every taken result word against the oldest owed one
    always @(posedge aclk) begin : result_watch
        bus_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing owed: scl %0b sda %0b busy %0b done %0b",
                       m_scl, m_sda_out, m_busy_res, m_done_res);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("scl", 32'(want.scl), 32'(m_scl));
                check_field("sda_out", 32'(want.sda), 32'(m_sda_out));
                check_field("busy_res", 32'(want.busy), 32'(m_busy_res));
                check_field("done_res", 32'(want.done), 32'(m_done_res));
                check_field("read_word", want.rd, m_read_word);
                check_field("nack_seen", 32'(want.nack), 32'(m_nack_seen));
            end
        end
    end

    initial begin : stimulus
        int         i;
        dir_row_t   row;
        bus_res_t   pred;
        logic [1:0] act;

        // predictor at its reset state
        cfg_dev = DEVICE_ADDRESS_RST;
        cfg_wait = WRITE_WAIT_RST;
        xf_op = OP_IDLE;
        xf_seg = SEG_START;
        xf_step = 0;
        xf_bytes = 0;
        xf_shift = '0;
        xf_buf = '0;
        xf_addr = '0;
        xf_nack = 1'b0;
        xf_wait = '0;
        line_scl = 1'b1;
        line_sda = 1'b1;
        last_read = '0;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DEVICE_ADDRESS;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_action <= ACT_TICK;
        s_mem_addr <= '0;
        s_write_word <= '0;
        s_sda_in <= 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed transfers, no idling; the last word of a typed row is checked
        // against its typed result, the rest against the predictor
        for (i = 0; i < DIR_ROWS_N; i++) begin
            row = DIR_ROWS[i];
            if (row.set_wait) begin
                settle();
                write_reg(REG_WRITE_WAIT, row.wait_val);
            end
            send_word(row.act, row.addr, row.word, row.mode, pred);
            while (xf_op != OP_IDLE) begin
                pending_results.push_back(pred);
                act = row.stray ? 2'($urandom_range(3)) : ACT_TICK;
                send_word(act, 8'($urandom), $urandom, row.mode, pred);
            end
            pending_results.push_back(row.typed ? row.res : pred);
        end

        // random phases, address and wait extremes among the settings
        run_phase(0, 0, 7'd0, 20'd0, PHASE_WORDS);
        run_phase(50, 0, 7'd127, 20'd1, PHASE_WORDS);
        run_phase(0, 50, 7'($urandom), 20'($urandom_range(40, 2)), PHASE_WORDS);
        run_phase(36, 36, 7'($urandom), 20'($urandom_range(5)), PHASE_WORDS);

        // longest wait: the write runs into it and the run ends part way through
        settle();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_reg(REG_WRITE_WAIT, WAIT_MAX);
        send_word(ACT_WRITE, 8'($urandom), $urandom, SDA_RAND, pred);
        pending_results.push_back(pred);
        while (xf_op != OP_WAIT) begin
            send_word(ACT_TICK, 8'($urandom), $urandom, SDA_RAND, pred);
            pending_results.push_back(pred);
        end
        for (i = 0; i < TAIL_TICKS; i++) begin
            send_word(2'($urandom_range(3)), 8'($urandom), $urandom, SDA_RAND, pred);
            pending_results.push_back(pred);
        end

        settle();
        if (mismatches == 0)
            $display("i2c_eeprom_word_transfer regression: pass");
        else
            $display("i2c_eeprom_word_transfer regression: fail");
        $finish;
    end

endmodule
